[design/bnsc_pkg.sv]
// Shared types and constants for the bus name syntax checker.
`timescale 1ns / 1ps

package bnsc_pkg;

	typedef enum logic [1:0] {
		KIND_PATH   = 2'd0,
		KIND_IFACE  = 2'd1,
		KIND_BUS    = 2'd2,
		KIND_MEMBER = 2'd3
	} name_kind_t;

	localparam int unsigned CNT_W        = 9;
	localparam int unsigned MAX_NAME_LEN = 255;

	localparam logic [CNT_W-1:0] CNT_SAT   = {CNT_W{1'b1}};
	localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_NAME_LEN);

	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_DASH   = 8'h2D;

endpackage

[design/bus_name_syntax_checker_top.sv]
// Top level of the bus name syntax checker: byte stream in, one verdict per name out.
`timescale 1ns / 1ps

//  channel   | ports                                   | request carries
//  ----------+-----------------------------------------+------------------------------------
//  s_axis    | tvalid, tready, tdata[7:0], tlast       | one byte of the name, last byte flag
//  m_axis    | tvalid, tready, tdata[7:0]              | verdict bit 0 = name valid
//  cfg       | cfg_wen, cfg_wdata[1:0]                 | rule set (path, iface, bus, member)
//
// Each byte request is checked by combinational logic while it sits in the input
// register; the verdict for a name loads into the output register at the edge that
// retires its last byte and raises m_axis_tvalid; a stall in the input register can delay it.
// One byte per cycle is sustained; the only stall holds a closing byte in the input
// register while the previous verdict is still waiting for m_axis_tready.
// Reset clears the name state, the rule set (object path) and both valid flags.

module bus_name_syntax_checker_top (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wen,
	input  bnsc_pkg::name_kind_t    cfg_wdata,
	input  logic                    s_axis_tvalid,
	output logic                    s_axis_tready,
	input  logic [7:0]              s_axis_tdata,   // [7:0] ch
	input  logic                    s_axis_tlast,
	output logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	output logic [7:0]              m_axis_tdata    // [0] valid_res, [7:1] zero
);
	import bnsc_pkg::*;

	// Rule set register.
	name_kind_t kind_q;

	// Input register.
	logic       vld_s1;
	logic [7:0] ch_s1;
	logic       last_s1;

	// Per-name state.
	logic [CNT_W-1:0] cnt_q;
	logic             psep_q;
	logic             seen_q;
	logic             fail_q;

	// Output register.
	logic out_vld_q;
	logic out_res_q;

	logic adv;
	logic is_first, is_alpha, is_digit, word;
	logic sep_ch;
	logic psep_n, seen_n, fail_n, fail_fin;
	logic [CNT_W-1:0] cnt_n;

	// Advance the byte in the input register unless its verdict has no room.
	assign adv           = vld_s1 && (!last_s1 || !out_vld_q || m_axis_tready);
	assign s_axis_tready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= KIND_PATH;
		end else if (cfg_wen) begin
			kind_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	// Payload: hold while stalled.
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			ch_s1   <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// Character classes of the byte under test; bytes with bit 7 set fall in none.
	always_comb begin
		is_first = (cnt_q == '0);
		is_alpha = (ch_s1 >= 8'h61 && ch_s1 <= 8'h7A) || (ch_s1 >= 8'h41 && ch_s1 <= 8'h5A);
		is_digit = (ch_s1 >= 8'h30 && ch_s1 <= 8'h39);
		word     = is_alpha || is_digit || (ch_s1 == CH_UNDER)
			|| (kind_q == KIND_BUS && ch_s1 == CH_DASH);
		sep_ch   = (kind_q == KIND_PATH) ? (ch_s1 == CH_SLASH) : (ch_s1 == CH_DOT);

		psep_n = psep_q;
		seen_n = seen_q;
		fail_n = fail_q;

		if (is_first) begin
			// First byte: each rule set has its own opening character rule.
			psep_n = 1'b0;
			unique case (kind_q)
				KIND_PATH: begin
					if (ch_s1 == CH_SLASH) psep_n = 1'b1;
					else                   fail_n = 1'b1;
				end
				KIND_BUS: begin
					if (ch_s1 == CH_COLON) begin
						seen_n = 1'b1;
						psep_n = 1'b1;
					end else if (!(is_alpha || ch_s1 == CH_UNDER || ch_s1 == CH_DASH)) begin
						fail_n = 1'b1;
					end
				end
				default: begin
					if (!(is_alpha || ch_s1 == CH_UNDER)) fail_n = 1'b1;
				end
			endcase
		end else if (word) begin
			psep_n = 1'b0;
		end else if (kind_q != KIND_MEMBER && sep_ch) begin
			// Separator: reject a doubled one, note a dot for non-path kinds.
			if (psep_q) fail_n = 1'b1;
			psep_n = 1'b1;
			if (kind_q != KIND_PATH) seen_n = 1'b1;
		end else begin
			fail_n = 1'b1;
		end

		// Count bytes, saturating; only paths may exceed the length limit.
		cnt_n = (cnt_q == CNT_SAT) ? cnt_q : cnt_q + 1'b1;
		if (kind_q != KIND_PATH && cnt_q >= CNT_LIMIT) fail_n = 1'b1;

		// Checks that only apply on the closing byte.
		fail_fin = fail_n;
		if (kind_q == KIND_PATH && !is_first && ch_s1 == CH_SLASH) fail_fin = 1'b1;
		if ((kind_q == KIND_IFACE || kind_q == KIND_BUS) && !seen_n) fail_fin = 1'b1;
	end

	// Name state: advance per byte, drop back to empty after the last byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			psep_q <= 1'b0;
			seen_q <= 1'b0;
			fail_q <= 1'b0;
		end else if (adv) begin
			if (last_s1) begin
				cnt_q  <= '0;
				psep_q <= 1'b0;
				seen_q <= 1'b0;
				fail_q <= 1'b0;
			end else begin
				cnt_q  <= cnt_n;
				psep_q <= psep_n;
				seen_q <= seen_n;
				fail_q <= fail_n;
			end
		end
	end

	// Verdict register: load on a closing byte, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv && last_s1) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			out_res_q <= !fail_fin;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {7'd0, out_res_q};

endmodule
